// ===== rtl/upd_pkg.sv =====
// shared types and constants for the url percent decoder
`default_nettype none

package upd_pkg;

  // most output words that one input word can cause
  localparam int unsigned MAX_WORDS = 3;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IDX_W = $clog2(MAX_WORDS);

  // one classified input word: up to three output bytes, in order
  typedef struct packed {
    logic [MAX_WORDS-1:0][7:0] data;
    logic [IDX_W-1:0]          last_idx;
    logic                      eos;
  } upd_rec_t;

endpackage

`default_nettype wire

// ===== rtl/upd_front.sv =====
// front: accepts input words, tracks escape state and builds result records
`default_nettype none

module upd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_of_string_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output upd_pkg::upd_rec_t      rec_o
);
  import upd_pkg::*;

  localparam logic [7:0] PercentChar = 8'h25;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_e;

  pend_e      pend_q, pend_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [IDX_W:0] cnt;
  logic [MAX_WORDS-1:0][7:0] data;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c <= 8'h46) begin
      t = c - 8'h37;
    end else begin
      t = c - 8'h57;
    end
    return t[3:0];
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    logic hex_ok;
    logic pct;
    hex_ok = is_hex(in_byte_i);
    pct    = (in_byte_i == PercentChar);
    pend_d = pend_q;
    held_d = held_q;
    cnt    = '0;
    data   = '0;
    if (accept) begin
      unique case (pend_q)
        PEND_PCT: begin
          if (hex_ok) begin
            held_d = in_byte_i;
            pend_d = PEND_DIGIT;
          end else begin
            data[cnt[IDX_W-1:0]] = PercentChar;
            cnt = cnt + 1'b1;
            if (pct) begin
              pend_d = PEND_PCT;
            end else begin
              data[cnt[IDX_W-1:0]] = in_byte_i;
              cnt = cnt + 1'b1;
              pend_d = PEND_NONE;
            end
          end
        end
        PEND_DIGIT: begin
          if (hex_ok) begin
            data[cnt[IDX_W-1:0]] = {hex_nib(held_q), hex_nib(in_byte_i)};
            cnt = cnt + 1'b1;
            pend_d = PEND_NONE;
          end else begin
            data[cnt[IDX_W-1:0]] = PercentChar;
            cnt = cnt + 1'b1;
            data[cnt[IDX_W-1:0]] = held_q;
            cnt = cnt + 1'b1;
            if (pct) begin
              pend_d = PEND_PCT;
            end else begin
              data[cnt[IDX_W-1:0]] = in_byte_i;
              cnt = cnt + 1'b1;
              pend_d = PEND_NONE;
            end
          end
        end
        default: begin
          if (pct) begin
            pend_d = PEND_PCT;
          end else begin
            data[cnt[IDX_W-1:0]] = in_byte_i;
            cnt = cnt + 1'b1;
            pend_d = PEND_NONE;
          end
        end
      endcase
      // flush whatever is still held at the end of the string
      if (end_of_string_i) begin
        if (pend_d == PEND_PCT) begin
          data[cnt[IDX_W-1:0]] = PercentChar;
          cnt = cnt + 1'b1;
        end else if (pend_d == PEND_DIGIT) begin
          data[cnt[IDX_W-1:0]] = PercentChar;
          cnt = cnt + 1'b1;
          data[cnt[IDX_W-1:0]] = held_d;
          cnt = cnt + 1'b1;
        end
        pend_d = PEND_NONE;
        held_d = '0;
      end
    end
  end

  assign push_o         = accept && (cnt != '0);
  assign rec_o.data     = data;
  assign rec_o.last_idx = IDX_W'(cnt - 1'b1);
  assign rec_o.eos      = end_of_string_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      held_q <= '0;
    end else begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

  // an accepted end of string always leaves nothing pending
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_string_i) |=> (pend_q == PEND_NONE))
    else $error("pending escape survived end of string");

  // an accepted end of string always yields at least one word
  a_eos_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_string_i) |-> push_o)
    else $error("end of string produced no word");

endmodule

`default_nettype wire

// ===== rtl/upd_queue.sv =====
// short record queue between front and back
`default_nettype none

module upd_queue #(
  parameter int unsigned Depth = upd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire upd_pkg::upd_rec_t rec_i,
  input  wire logic              pop_i,
  output upd_pkg::upd_rec_t      head_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upd_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/upd_back.sv =====
// back: plays records into output register, one word per unstalled cycle
`default_nettype none

module upd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire upd_pkg::upd_rec_t head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o,
  output logic                   string_done_o
);
  import upd_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             done_q, done_d;
  logic             load;
  logic             at_end;

  assign load   = !empty_i && (!valid_q || !out_stall_i);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    done_d  = done_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = head_i.data[idx_q];
      last_d  = at_end;
      done_d  = at_end && head_i.eos;
      idx_d   = at_end ? '0 : idx_q + 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign string_done_o = done_q;

  // the word index never runs past the record at the head
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q <= head_i.last_idx))
    else $error("word index beyond record");

endmodule

`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// top level of the url percent decoder
// usage:
//   input channel carries one word per raw byte of the encoded string,
//   with end_of_string_i set on the last byte of each string
//   output channel carries the decoded bytes; last_of_run_o marks the final
//   output word caused by an input word, string_done_o the final word of a string
//   a '%' plus two hex digits becomes one byte; broken escapes pass through raw
// path:
//   an accepted word's record is written into the queue register, then its
//   first output word is loaded from the queue head into the output register
// throughput:
//   one input word per cycle while the queue has room; an input word that
//   yields k output words (k is 0 to 3) holds the back end until all k are taken,
//   and words that yield nothing (a held '%' or digit) never enter the queue
// reset:
//   clears the escape state, empties the queue and drops out_valid_o
// stall:
//   out_stall_i freezes the output register; the queue keeps filling until
//   full, then in_stall_o rises (it depends on the queue fill only)
`default_nettype none

module url_percent_decoder #(
  parameter int unsigned QueueDepth = upd_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            string_done_o
);
  import upd_pkg::*;

  // records handed from front to queue and from queue to back
  upd_rec_t push_rec;
  upd_rec_t head_rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // front: classifies each byte against the held escape prefix
  upd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .rec_o           (push_rec)
  );

  // decouples a 3-word record from the next input byte
  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .head_o  (head_rec),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: one output word per unstalled cycle from the head record
  upd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_rec),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_done_o (string_done_o)
  );

endmodule

`default_nettype wire

// ===== dv/url_percent_decoder_tb.sv =====
`timescale 1ns / 100ps
// testbench for the url percent decoder: directed and random strings checked by a scoreboard

module url_percent_decoder_tb;

  localparam logic [7:0] PERCENT = 8'h25;
  localparam int NOT_HEX = -1;
  localparam int IDLE_LIMIT = 2000;     // cycles without any word moving
  localparam int RANDOM_WORDS = 360;
  localparam int HOLD_CYCLES = 100;     // long receiver hold-off
  localparam int MAX_SHOWN = 10;

  // escape scan state of the predictor
  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_DIGIT
  } esc_state_e;

  // one decoded word as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_done;
  } dec_word_t;

  typedef logic [7:0] byte_q_t[$];

  // nibble value of an ascii hex digit, NOT_HEX for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return NOT_HEX;
  endfunction

  // predicts decoded words per input word and checks them in order
  class decode_scoreboard;
    dec_word_t   due_q[$];
    dec_word_t   run_q[$];
    esc_state_e  esc;
    logic [7:0]  held_char;
    int unsigned n_words_in, n_words_out, n_escapes, n_broken, n_mismatch;

    function new();
      esc = ESC_NONE;
      held_char = '0;
    endfunction

    function void add_byte(input logic [7:0] b);
      run_q.push_back('{data: b, run_last: 1'b0, str_done: 1'b0});
    endfunction

    // a byte met with no escape open
    function void take_fresh(input logic [7:0] b);
      if (b == PERCENT) esc = ESC_PCT;
      else add_byte(b);
    endfunction

    function void note_input(input logic [7:0] b, input logic eos);
      int lo, hi;
      run_q.delete();
      n_words_in++;
      case (esc)
        ESC_PCT: begin
          if (hex_nibble(b) != NOT_HEX) begin
            held_char = b;
            esc = ESC_DIGIT;
          end else begin
            // broken escape, rescan this byte from scratch
            esc = ESC_NONE;
            n_broken++;
            add_byte(PERCENT);
            take_fresh(b);
          end
        end
        ESC_DIGIT: begin
          lo = hex_nibble(b);
          esc = ESC_NONE;
          if (lo != NOT_HEX) begin
            hi = hex_nibble(held_char);
            add_byte(8'(hi * 16 + lo));
            n_escapes++;
          end else begin
            n_broken++;
            add_byte(PERCENT);
            add_byte(held_char);
            take_fresh(b);
          end
        end
        default: begin
          esc = ESC_NONE;
          take_fresh(b);
        end
      endcase
      // end of string flushes whatever escape is still open
      if (eos) begin
        if (esc == ESC_PCT) begin
          add_byte(PERCENT);
        end else if (esc == ESC_DIGIT) begin
          add_byte(PERCENT);
          add_byte(held_char);
        end
        esc = ESC_NONE;
        held_char = '0;
      end
      if (run_q.size() > 0) begin
        run_q[run_q.size() - 1].run_last = 1'b1;
        if (eos) run_q[run_q.size() - 1].str_done = 1'b1;
      end
      foreach (run_q[i]) due_q.push_back(run_q[i]);
    endfunction

    function void check_output(input logic [7:0] data, input logic run_last,
                               input logic str_done);
      dec_word_t want;
      n_words_out++;
      if (due_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN)
          $display("%0t: unexpected word data=%02h run_last=%b str_done=%b",
                   $realtime, data, run_last, str_done);
        return;
      end
      want = due_q.pop_front();
      if (data !== want.data || run_last !== want.run_last || str_done !== want.str_done)
      begin
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN)
          $display("%0t: mismatch data %02h/%02h run_last %b/%b str_done %b/%b (exp/act)",
                   $realtime, want.data, data, want.run_last, run_last,
                   want.str_done, str_done);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       string_done_o;

  decode_scoreboard sb = new();

  url_percent_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .string_done_o  (string_done_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // receiver: random stall bursts, stall-free stretches, and on request one long hold
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned n_holds = 0;
  int          stall_left = 0;
  int          free_left = 0;
  int          rx_pick;

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      // long hold-off counted here, sender keeps offering meanwhile
      hold_seen = hold_req;
      stall_left = HOLD_CYCLES;
      free_left = 0;
      n_holds++;
    end else if (stall_left == 0 && free_left == 0) begin
      rx_pick = $urandom_range(99);
      if (rx_pick < 8) free_left = $urandom_range(60, 20);
      else if (rx_pick < 12) stall_left = $urandom_range(30, 8);
      else if (rx_pick < 40) stall_left = $urandom_range(3, 1);
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
    else if (free_left > 0) free_left--;
  end

  // output words are sampled mid-cycle, where everything has settled
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_output(out_byte_o, last_of_run_o, string_done_o);
  end

  // watchdog on cycles where neither channel moves a word
  int idle_cycles = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles, %0d words still due",
                   IDLE_LIMIT, sb.due_q.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  bit gaps_on = 1'b1;
  int unsigned n_strings = 0;

  // offer one word and wait until it is taken; entered and left at a rising edge
  task automatic send_word(input logic [7:0] b, input logic eos);
    logic took;
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_string_i <= eos;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      if (took) sb.note_input(b, eos);
      @(posedge clk_i);
    end while (!took);
  endtask

  // sender gap: mostly none or short, now and then long
  task automatic pause_sender();
    int pick, n;
    pick = $urandom_range(99);
    if (!gaps_on || pick < 65) n = 0;
    else if (pick < 92) n = $urandom_range(3, 1);
    else n = $urandom_range(30, 8);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      in_byte_i <= 8'($urandom);
      end_of_string_i <= 1'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_string(input byte_q_t s);
    foreach (s[i]) begin
      send_word(s[i], i == s.size() - 1);
      pause_sender();
    end
    n_strings++;
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(1)) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  // any byte, weighted toward '%', hex digits and the edges of the hex ranges
  function automatic logic [7:0] noise_char();
    logic [7:0] edge_chars[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return PERCENT;
    if (pick < 5) return hex_char();
    if (pick < 7) return edge_chars[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed escapes with random content, some broken ones and noise
  function automatic byte_q_t build_string(input int n_tokens);
    byte_q_t s;
    int pick;
    repeat (n_tokens) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        s.push_back(PERCENT);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (pick < 62) begin
        s.push_back(PERCENT);
        if ($urandom_range(1)) s.push_back(hex_char());
      end else begin
        s.push_back(noise_char());
      end
    end
    return s;
  endfunction

  int unsigned random_words;
  byte_q_t     str;

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    end_of_string_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: raw extremes, both digit cases, broken and unfinished escapes
    send_string('{8'h00, 8'hFF});
    send_string('{PERCENT, "4", "1"});
    send_string('{PERCENT, "a", "F"});
    send_string('{PERCENT, "G", "x"});            // non-hex right after '%'
    send_string('{PERCENT, "4", PERCENT, "4", "1"}); // '%' breaks a half escape
    send_string('{PERCENT, PERCENT});             // second '%' reopens, flushed at end
    send_string('{PERCENT});                      // lone '%' at end of string
    send_string('{PERCENT, "9"});                 // one digit held at end
    send_string('{PERCENT, "F", PERCENT});        // three words from one input

    // random strings, one burst against a long receiver hold
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if (n_strings == 15) begin
        hold_req++;
        gaps_on = 1'b0;
        str = build_string(20);
      end else begin
        gaps_on = ($urandom_range(3) != 0);
        str = build_string($urandom_range(9) == 0 ? $urandom_range(20, 10)
                                                  : $urandom_range(6, 1));
      end
      send_string(str);
      random_words += str.size();
    end

    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d strings, %0d input words, %0d decoded words; %0d escapes decoded,",
             n_strings, sb.n_words_in, sb.n_words_out, sb.n_escapes);
    $display("%0d broken escapes, %0d long receiver holds, %0d mismatches",
             sb.n_broken, n_holds, sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
